// ===== design/mrpe_pkg.sv =====
// types, constants and the update microprogram of the rls parameter estimator
`timescale 1ns / 1ps
package mrpe_pkg;

  localparam int W       = 48;
  localparam int AW      = 5;
  localparam int DEPTH   = 32;
  localparam int PC_W    = 6;
  localparam int CNT_W   = 6;

  typedef logic [AW-1:0]   addr_t;
  typedef logic [PC_W-1:0] pc_t;
  typedef logic [W-1:0]    word_t;

  localparam word_t SAT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam word_t SAT_MIN = {1'b1, {(W-1){1'b0}}};

  localparam pc_t            PC_LAST   = 6'd56;
  localparam pc_t            INIT_LAST = 6'd7;
  localparam logic [CNT_W-1:0] MUL_LAST = 6'd2;
  localparam logic [CNT_W-1:0] DIV_LAST = 6'd63;

  // scaling to amps and volts: round(m / den) with m already shifted
  localparam logic [63:0] AMP_DEN   = 64'd3193;
  localparam logic [63:0] AMP_HALF  = 64'd1596;
  localparam logic [63:0] VOLT_DEN  = 64'd11824;
  localparam logic [63:0] VOLT_HALF = 64'd5912;

  // scratch memory map; the first eight entries are loaded after reset
  localparam addr_t A_P0    = 5'd0;
  localparam addr_t A_P1    = 5'd1;
  localparam addr_t A_P2    = 5'd2;
  localparam addr_t A_P3    = 5'd3;
  localparam addr_t A_TH0   = 5'd4;
  localparam addr_t A_TH1   = 5'd5;
  localparam addr_t A_ONE   = 5'd6;
  localparam addr_t A_ZERO  = 5'd7;
  localparam addr_t A_PHI0  = 5'd8;
  localparam addr_t A_PHI1  = 5'd9;
  localparam addr_t A_Y     = 5'd10;
  localparam addr_t A_TA    = 5'd11;
  localparam addr_t A_TB    = 5'd12;
  localparam addr_t A_M00_0 = 5'd13;
  localparam addr_t A_M00_1 = 5'd14;
  localparam addr_t A_M01_0 = 5'd15;
  localparam addr_t A_M01_1 = 5'd16;
  localparam addr_t A_AB    = 5'd17;
  localparam addr_t A_K0    = 5'd18;
  localparam addr_t A_K1    = 5'd19;
  localparam addr_t A_Q00   = 5'd20;
  localparam addr_t A_Q01   = 5'd21;
  localparam addr_t A_Q10   = 5'd22;
  localparam addr_t A_Q11   = 5'd23;
  localparam addr_t A_N00   = 5'd24;
  localparam addr_t A_N01   = 5'd25;
  localparam addr_t A_N10   = 5'd26;
  localparam addr_t A_N11   = 5'd27;
  localparam addr_t A_G0    = 5'd28;
  localparam addr_t A_G1    = 5'd29;
  localparam addr_t A_E     = 5'd30;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_RCP
  } op_e;

  typedef struct packed {
    op_e   op;
    addr_t dst;
    addr_t src_a;
    addr_t src_b;
  } uop_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_LP_SET,
    ST_LP_DIV,
    ST_LP_DONE,
    ST_SC_SET,
    ST_SC_DONE,
    ST_SP_SET,
    ST_SP_DONE,
    ST_RD,
    ST_EXE,
    ST_MUL,
    ST_DIV,
    ST_MUL_WR,
    ST_RCP_WR,
    ST_OUT
  } state_e;

  function automatic uop_t mk(input op_e op, input addr_t d, input addr_t a, input addr_t b);
    uop_t u;
    u.op    = op;
    u.dst   = d;
    u.src_a = a;
    u.src_b = b;
    return u;
  endfunction

  // one rls update: gain, covariance and estimate
  function automatic uop_t mrpe_uop(input pc_t pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(OP_MUL, A_TA,    A_P0,    A_PHI0);
      6'd1:  u = mk(OP_MUL, A_TB,    A_P1,    A_PHI1);
      6'd2:  u = mk(OP_ADD, A_M00_0, A_TA,    A_TB);
      6'd3:  u = mk(OP_MUL, A_TA,    A_P2,    A_PHI0);
      6'd4:  u = mk(OP_MUL, A_TB,    A_P3,    A_PHI1);
      6'd5:  u = mk(OP_ADD, A_M00_1, A_TA,    A_TB);
      6'd6:  u = mk(OP_MUL, A_TA,    A_PHI0,  A_P0);
      6'd7:  u = mk(OP_MUL, A_TB,    A_PHI1,  A_P2);
      6'd8:  u = mk(OP_ADD, A_M01_0, A_TA,    A_TB);
      6'd9:  u = mk(OP_MUL, A_TA,    A_PHI0,  A_P1);
      6'd10: u = mk(OP_MUL, A_TB,    A_PHI1,  A_P3);
      6'd11: u = mk(OP_ADD, A_M01_1, A_TA,    A_TB);
      6'd12: u = mk(OP_MUL, A_TA,    A_M01_0, A_PHI0);
      6'd13: u = mk(OP_MUL, A_TB,    A_M01_1, A_PHI1);
      6'd14: u = mk(OP_ADD, A_AB,    A_TA,    A_TB);
      6'd15: u = mk(OP_ADD, A_AB,    A_ONE,   A_AB);
      6'd16: u = mk(OP_RCP, A_AB,    A_AB,    A_AB);
      6'd17: u = mk(OP_MUL, A_K0,    A_M00_0, A_AB);
      6'd18: u = mk(OP_MUL, A_K1,    A_M00_1, A_AB);
      6'd19: u = mk(OP_MUL, A_Q00,   A_K0,    A_PHI0);
      6'd20: u = mk(OP_MUL, A_Q01,   A_K0,    A_PHI1);
      6'd21: u = mk(OP_MUL, A_Q10,   A_K1,    A_PHI0);
      6'd22: u = mk(OP_MUL, A_Q11,   A_K1,    A_PHI1);
      6'd23: u = mk(OP_MUL, A_TA,    A_Q00,   A_P0);
      6'd24: u = mk(OP_MUL, A_TB,    A_Q01,   A_P2);
      6'd25: u = mk(OP_ADD, A_TA,    A_TA,    A_TB);
      6'd26: u = mk(OP_SUB, A_N00,   A_P0,    A_TA);
      6'd27: u = mk(OP_MUL, A_TA,    A_Q00,   A_P1);
      6'd28: u = mk(OP_MUL, A_TB,    A_Q01,   A_P3);
      6'd29: u = mk(OP_ADD, A_TA,    A_TA,    A_TB);
      6'd30: u = mk(OP_SUB, A_N01,   A_P1,    A_TA);
      6'd31: u = mk(OP_MUL, A_TA,    A_Q10,   A_P0);
      6'd32: u = mk(OP_MUL, A_TB,    A_Q11,   A_P2);
      6'd33: u = mk(OP_ADD, A_TA,    A_TA,    A_TB);
      6'd34: u = mk(OP_SUB, A_N10,   A_P2,    A_TA);
      6'd35: u = mk(OP_MUL, A_TA,    A_Q10,   A_P1);
      6'd36: u = mk(OP_MUL, A_TB,    A_Q11,   A_P3);
      6'd37: u = mk(OP_ADD, A_TA,    A_TA,    A_TB);
      6'd38: u = mk(OP_SUB, A_N11,   A_P3,    A_TA);
      6'd39: u = mk(OP_MUL, A_TA,    A_N00,   A_PHI0);
      6'd40: u = mk(OP_MUL, A_TB,    A_N01,   A_PHI1);
      6'd41: u = mk(OP_ADD, A_G0,    A_TA,    A_TB);
      6'd42: u = mk(OP_MUL, A_TA,    A_N10,   A_PHI0);
      6'd43: u = mk(OP_MUL, A_TB,    A_N11,   A_PHI1);
      6'd44: u = mk(OP_ADD, A_G1,    A_TA,    A_TB);
      6'd45: u = mk(OP_MUL, A_TA,    A_PHI0,  A_TH0);
      6'd46: u = mk(OP_MUL, A_TB,    A_PHI1,  A_TH1);
      6'd47: u = mk(OP_ADD, A_TA,    A_TA,    A_TB);
      6'd48: u = mk(OP_SUB, A_E,     A_Y,     A_TA);
      6'd49: u = mk(OP_MUL, A_TA,    A_G0,    A_E);
      6'd50: u = mk(OP_ADD, A_TH0,   A_TH0,   A_TA);
      6'd51: u = mk(OP_MUL, A_TA,    A_G1,    A_E);
      6'd52: u = mk(OP_ADD, A_TH1,   A_TH1,   A_TA);
      6'd53: u = mk(OP_ADD, A_P0,    A_N00,   A_ZERO);
      6'd54: u = mk(OP_ADD, A_P1,    A_N01,   A_ZERO);
      6'd55: u = mk(OP_ADD, A_P2,    A_N10,   A_ZERO);
      6'd56: u = mk(OP_ADD, A_P3,    A_N11,   A_ZERO);
      default: u = mk(OP_ADD, A_TA, A_ZERO, A_ZERO);
    endcase
    return u;
  endfunction

  function automatic word_t mag48(input word_t v);
    return v[W-1] ? (word_t'(0) - v) : v;
  endfunction

  function automatic logic [15:0] mag16(input logic [15:0] v);
    return v[15] ? (16'd0 - v) : v;
  endfunction

  // saturating add or subtract of two signed words
  function automatic word_t sat_add(input word_t a, input word_t b, input logic sub);
    logic [W:0] s;
    if (sub) begin
      s = {a[W-1], a} - {b[W-1], b};
    end else begin
      s = {a[W-1], a} + {b[W-1], b};
    end
    if (s[W] != s[W-1]) begin
      return s[W] ? SAT_MIN : SAT_MAX;
    end
    return s[W-1:0];
  endfunction

  // magnitude with sign applied, saturated to the word range
  function automatic word_t sat_mag(input logic [63:0] m, input logic neg);
    word_t r;
    if (|m[63:W-1]) begin
      r = neg ? SAT_MIN : SAT_MAX;
    end else if (neg) begin
      r = word_t'(0) - {1'b0, m[W-2:0]};
    end else begin
      r = {1'b0, m[W-2:0]};
    end
    return r;
  endfunction

endpackage

// ===== design/mrpe_ram.sv =====
// generic single-write, dual-read ram with registered read data
`timescale 1ns / 1ps
module mrpe_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== design/motor_rls_parameter_estimator_unit.sv =====
// top level of the two-parameter rls motor estimator with its sequencer and shared units
//
//  channel  | direction | handshake              | payload
//  s_axis   | in        | tvalid/tready          | tdata: iq, vq, speed
//  m_axis   | out       | tvalid/tready          | tdata: theta0, theta1, i filt, v filt
//  cfg      | in        | cfg_we_i               | cfg_wdata_i: filter bandwidth
//
// each item passes through the 64-step restoring divider (three divisions per item: two
// filters and the reciprocal, skipped when 1 + a is zero) and the 48x16 multiplier that
// needs three passes per product, both shared by all steps; no new item is accepted
// until the result of the last one is loaded into the output register
// after reset a sweep loads covariance, estimates and constants into the first eight
// entries of the scratch ram; no item is accepted meanwhile
// a held result blocks only the final load of the next result
`timescale 1ns / 1ps
module motor_rls_parameter_estimator_unit #(
  parameter int FRACTION_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // iq_sample, vq_sample, speed_rpm
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata    // estimate_resistance, estimate_emf_constant,
                                      // filtered_current, filtered_voltage
);

  import mrpe_pkg::*;

  localparam int          F        = FRACTION_BITS;
  localparam logic [63:0] BIG_RAW  = 64'd1000000 << F;
  localparam word_t       P_INIT   = (|BIG_RAW[63:W-1]) ? SAT_MAX : BIG_RAW[W-1:0];
  localparam logic [63:0] TH_RAW   = ((64'd1 << F) + 64'd50) / 64'd100;
  localparam logic [63:0] ONE_RAW  = 64'd1 << F;
  localparam logic [63:0] RCP_NUM  = 64'd1 << (2 * F);
  localparam logic [63:0] SPD_RAW  =
    ((64'd1 << F) * 64'd15707963 + 64'd75000000) / 64'd150000000;

  // exact quotients by reciprocal multiplication; volts drop the factor 16 first
  localparam int          AMP_K      = F + 29;
  localparam int          VOLT_K     = F + 24;
  localparam logic [63:0] AMP_MAGIC  = ((64'd1 << AMP_K) + AMP_DEN - 64'd1) / AMP_DEN;
  localparam logic [63:0] VOLT_MAGIC =
    ((64'd1 << VOLT_K) + (VOLT_DEN >> 4) - 64'd1) / (VOLT_DEN >> 4);

  function automatic word_t fmul_sat(input logic [95:0] p, input logic neg);
    logic [95:0] sh;
    logic [63:0] m;
    sh = p >> F;
    m  = (|sh[95:64]) ? {64{1'b1}} : sh[63:0];
    return sat_mag(m, neg);
  endfunction

  function automatic logic [31:0] to_q16(input word_t v);
    word_t       m;
    logic [31:0] r;
    m = mag48(v) >> (F - 16);
    if (v[W-1]) begin
      r = (|m[W-1:31]) ? 32'h8000_0000 : (32'd0 - m[31:0]);
    end else begin
      r = (|m[W-1:31]) ? 32'h7fff_ffff : m[31:0];
    end
    return r;
  endfunction

  state_e             state_q, state_d, ret_q, ret_d;
  pc_t                pc_q, pc_d;
  logic               chan_q, chan_d;
  logic [15:0]        bw_q, bw_d;
  logic [15:0]        cur_avg_q, cur_avg_d, volt_avg_q, volt_avg_d;
  logic [15:0]        iq_q, iq_d, vq_q, vq_d, spd_q, spd_d;
  logic               sign_q, sign_d;
  word_t              mul_a_q, mul_a_d, mul_b_q, mul_b_d;
  logic [95:0]        acc_q, acc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [63:0]        num_q, num_d, quo_q, quo_d;
  word_t              den_q, den_d, rem_q, rem_d;
  word_t              th0_q, th0_d, th1_q, th1_d;
  logic               out_valid_q, out_valid_d;
  logic [31:0]        o_res_q, o_res_d, o_emf_q, o_emf_d;
  logic [15:0]        o_cur_q, o_cur_d, o_volt_q, o_volt_d;

  uop_t        uop;
  word_t       rdata_a, rdata_b;
  logic        wr_en;
  addr_t       wr_addr;
  word_t       wr_data;
  logic [15:0] bw_eff;

  logic [15:0] lp_avg, lp_x, m16;
  logic [33:0] lp_sum, lp_mag;
  logic [15:0] chunk, q16;
  logic [63:0] part;
  logic [95:0] part_sh;
  logic [W:0]  rem_sh;
  logic        ge;
  logic [63:0] sc_m, sc_n, sc_q;
  logic [95:0] sc_acc;

  assign uop    = mrpe_uop(pc_q);
  assign bw_eff = (bw_q == 16'd0) ? 16'd1 : bw_q;

  mrpe_ram #(
    .WIDTH (W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (wr_addr),
    .wdata_i   (wr_data),
    .raddr_a_i (uop.src_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (uop.src_b),
    .rdata_b_o (rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      ret_q       <= ST_IDLE;
      pc_q        <= '0;
      chan_q      <= 1'b0;
      bw_q        <= 16'd128;
      cur_avg_q   <= '0;
      volt_avg_q  <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      pc_q        <= pc_d;
      chan_q      <= chan_d;
      bw_q        <= bw_d;
      cur_avg_q   <= cur_avg_d;
      volt_avg_q  <= volt_avg_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iq_q     <= iq_d;
    vq_q     <= vq_d;
    spd_q    <= spd_d;
    sign_q   <= sign_d;
    mul_a_q  <= mul_a_d;
    mul_b_q  <= mul_b_d;
    acc_q    <= acc_d;
    num_q    <= num_d;
    quo_q    <= quo_d;
    den_q    <= den_d;
    rem_q    <= rem_d;
    th0_q    <= th0_d;
    th1_q    <= th1_d;
    o_res_q  <= o_res_d;
    o_emf_q  <= o_emf_d;
    o_cur_q  <= o_cur_d;
    o_volt_q <= o_volt_d;
  end

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    pc_d        = pc_q;
    chan_d      = chan_q;
    bw_d        = cfg_we_i ? cfg_wdata_i : bw_q;
    cur_avg_d   = cur_avg_q;
    volt_avg_d  = volt_avg_q;
    iq_d        = iq_q;
    vq_d        = vq_q;
    spd_d       = spd_q;
    sign_d      = sign_q;
    mul_a_d     = mul_a_q;
    mul_b_d     = mul_b_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    num_d       = num_q;
    quo_d       = quo_q;
    den_d       = den_q;
    rem_d       = rem_q;
    o_res_d     = o_res_q;
    o_emf_d     = o_emf_q;
    o_cur_d     = o_cur_q;
    o_volt_d    = o_volt_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    wr_en       = 1'b0;
    wr_addr     = uop.dst;
    wr_data     = '0;
    s_axis_tready = 1'b0;

    lp_avg  = chan_q ? volt_avg_q : cur_avg_q;
    lp_x    = chan_q ? vq_q : iq_q;
    m16     = chan_q ? mag16(volt_avg_q) : mag16(cur_avg_q);
    lp_sum  = (sign_q ? (34'd0 - {2'b0, acc_q[31:0]}) : {2'b0, acc_q[31:0]})
              + {{18{lp_x[15]}}, lp_x};
    lp_mag  = lp_sum[33] ? (34'd0 - lp_sum) : lp_sum;
    q16     = quo_q[15:0];
    sc_m    = chan_q ? ((({48'd0, m16} << 2) + {48'd0, m16}) << F) + VOLT_HALF
                     : ({48'd0, m16} << (F + 1)) + AMP_HALF;
    sc_n    = chan_q ? (sc_m >> 4) : sc_m;
    sc_acc  = chan_q ? (acc_q >> VOLT_K) : (acc_q >> AMP_K);
    sc_q    = sc_acc[63:0];

    case (cnt_q[1:0])
      2'd0:    chunk = mul_b_q[15:0];
      2'd1:    chunk = mul_b_q[31:16];
      default: chunk = mul_b_q[47:32];
    endcase
    part    = mul_a_q * chunk;
    part_sh = {32'd0, part} << {cnt_q[1:0], 4'd0};

    rem_sh  = {rem_q, num_q[63]};
    ge      = rem_sh >= {1'b0, den_q};

    case (state_q)
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_addr = pc_q[AW-1:0];
        if (wr_addr == A_P0 || wr_addr == A_P3) begin
          wr_data = P_INIT;
        end else if (wr_addr == A_TH0 || wr_addr == A_TH1) begin
          wr_data = TH_RAW[W-1:0];
        end else if (wr_addr == A_ONE) begin
          wr_data = ONE_RAW[W-1:0];
        end
        pc_d = pc_q + 1'b1;
        if (pc_q == INIT_LAST) begin
          pc_d    = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          iq_d    = s_axis_tdata[15:0];
          vq_d    = s_axis_tdata[31:16];
          spd_d   = s_axis_tdata[47:32];
          chan_d  = 1'b0;
          state_d = ST_LP_SET;
        end
      end
      ST_LP_SET: begin
        // |avg| * (bw - 1) on the shared multiplier
        mul_a_d = {32'd0, m16};
        mul_b_d = {32'd0, bw_eff - 16'd1};
        sign_d  = lp_avg[15];
        acc_d   = '0;
        cnt_d   = '0;
        ret_d   = ST_LP_DIV;
        state_d = ST_MUL;
      end
      ST_LP_DIV: begin
        num_d   = {30'd0, lp_mag};
        den_d   = {32'd0, bw_eff};
        sign_d  = lp_sum[33];
        rem_d   = '0;
        quo_d   = '0;
        cnt_d   = '0;
        ret_d   = ST_LP_DONE;
        state_d = ST_DIV;
      end
      ST_LP_DONE: begin
        if (chan_q) begin
          volt_avg_d = sign_q ? (16'd0 - q16) : q16;
          chan_d     = 1'b0;
          state_d    = ST_SC_SET;
        end else begin
          cur_avg_d = sign_q ? (16'd0 - q16) : q16;
          chan_d    = 1'b1;
          state_d   = ST_LP_SET;
        end
      end
      ST_SC_SET: begin
        // rounded dividend times the reciprocal of the scale divisor
        mul_a_d = sc_n[W-1:0];
        mul_b_d = chan_q ? VOLT_MAGIC[W-1:0] : AMP_MAGIC[W-1:0];
        sign_d  = lp_avg[15];
        acc_d   = '0;
        cnt_d   = '0;
        ret_d   = ST_SC_DONE;
        state_d = ST_MUL;
      end
      ST_SC_DONE: begin
        wr_en   = 1'b1;
        wr_addr = chan_q ? A_Y : A_PHI0;
        wr_data = sat_mag(sc_q, sign_q);
        chan_d  = !chan_q;
        state_d = chan_q ? ST_SP_SET : ST_SC_SET;
      end
      ST_SP_SET: begin
        mul_a_d = SPD_RAW[W-1:0];
        mul_b_d = {32'd0, mag16(spd_q)};
        sign_d  = spd_q[15];
        acc_d   = '0;
        cnt_d   = '0;
        ret_d   = ST_SP_DONE;
        state_d = ST_MUL;
      end
      ST_SP_DONE: begin
        wr_en   = 1'b1;
        wr_addr = A_PHI1;
        wr_data = sat_mag(acc_q[63:0], sign_q);
        pc_d    = '0;
        state_d = ST_RD;
      end
      ST_RD: begin
        state_d = ST_EXE;
      end
      ST_EXE: begin
        case (uop.op)
          OP_MUL: begin
            mul_a_d = mag48(rdata_a);
            mul_b_d = mag48(rdata_b);
            sign_d  = rdata_a[W-1] ^ rdata_b[W-1];
            acc_d   = '0;
            cnt_d   = '0;
            ret_d   = ST_MUL_WR;
            state_d = ST_MUL;
          end
          OP_RCP: begin
            if (rdata_a == '0) begin
              // zero denominator gives the largest positive value
              wr_en   = 1'b1;
              wr_data = SAT_MAX;
              pc_d    = pc_q + 1'b1;
              state_d = ST_RD;
            end else begin
              num_d   = RCP_NUM;
              den_d   = mag48(rdata_a);
              sign_d  = rdata_a[W-1];
              rem_d   = '0;
              quo_d   = '0;
              cnt_d   = '0;
              ret_d   = ST_RCP_WR;
              state_d = ST_DIV;
            end
          end
          default: begin
            wr_en   = 1'b1;
            wr_data = sat_add(rdata_a, rdata_b, uop.op == OP_SUB);
            pc_d    = pc_q + 1'b1;
            state_d = (pc_q == PC_LAST) ? ST_OUT : ST_RD;
          end
        endcase
      end
      ST_MUL: begin
        acc_d = acc_q + part_sh;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == MUL_LAST) begin
          state_d = ret_q;
        end
      end
      ST_DIV: begin
        rem_d = ge ? rem_sh[W-1:0] - den_q : rem_sh[W-1:0];
        quo_d = {quo_q[62:0], ge};
        num_d = num_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = ret_q;
        end
      end
      ST_MUL_WR: begin
        wr_en   = 1'b1;
        wr_data = fmul_sat(acc_q, sign_q);
        pc_d    = pc_q + 1'b1;
        state_d = (pc_q == PC_LAST) ? ST_OUT : ST_RD;
      end
      ST_RCP_WR: begin
        wr_en   = 1'b1;
        wr_data = sat_mag(quo_q, sign_q);
        pc_d    = pc_q + 1'b1;
        state_d = (pc_q == PC_LAST) ? ST_OUT : ST_RD;
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          o_res_d     = to_q16(th0_q);
          o_emf_d     = to_q16(th1_q);
          o_cur_d     = cur_avg_q;
          o_volt_d    = volt_avg_q;
          out_valid_d = 1'b1;
          pc_d        = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // estimates are kept beside the ram for the output conversion
    th0_d = (wr_en && wr_addr == A_TH0) ? wr_data : th0_q;
    th1_d = (wr_en && wr_addr == A_TH1) ? wr_data : th1_q;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {o_volt_q, o_cur_q, o_emf_q, o_res_q};

endmodule
